@@ hdl/positional_list_store_unit_defines.svh @@
// Assertion macros for the list store unit.
// They use the clk_i and rst_ni of the module that invokes them.
`ifndef POSITIONAL_LIST_STORE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_STORE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define PLS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PLS_ASSERT_IMPLY(lbl, ante, cons, msg)
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/pls_pkg.sv @@
package pls_pkg;

  localparam int PLS_CAPACITY = 64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT,
    S_FETCH,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic latch;
    logic read;
    logic write;
    logic put;
    logic fetch;
    logic drop;
    logic load_out;
  } pls_cmd_t;

  typedef struct packed {
    logic go_shift;
    logic go_fetch;
    logic more;
    logic is_insert;
  } pls_stat_t;

endpackage

@@ hdl/positional_list_store_unit.sv @@
// Ordered list store of up to CAPACITY signed 32-bit words.
// Input channel: op_i, position_i, value_i with in_valid_i / in_stall_o.
//   A word is taken on a clock edge with valid high and stall low.
// Output channel: read_value_o, entry_total_o, is_empty_o, status_o with
//   out_valid_o / out_stall_i; exactly one result word per input word.
// Entries live in a single-port-write, single-read memory; insert and delete
//   move the later entries one at a time, each with a read and then a write.
// Insert runs the shift loop, then puts the new word; delete runs the loop
//   and then drops one entry; read fetches; clear or a refused op goes straight
//   to the result. The next word is taken the cycle after the result is
//   loaded; no new word is taken while an earlier one is still worked on.
// A finished result sits in the output register while the next word is
//   taken; if the receiver stalls, a second result waits in the unit until
//   the register frees.
// Reset empties the list and drops any pending result; memory contents are
//   not cleared, no clearing pass is needed.
module positional_list_store_unit import pls_pkg::*; #(
  parameter int CAPACITY = PLS_CAPACITY
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [15:0]        position_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] read_value_o,
  output logic [6:0]         entry_total_o,
  output logic               is_empty_o,
  output logic [1:0]         status_o
);

  pls_cmd_t  cmd;
  pls_stat_t stat;

  pls_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pls_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .read_value_o  (read_value_o),
    .entry_total_o (entry_total_o),
    .is_empty_o    (is_empty_o),
    .status_o      (status_o)
  );

endmodule

@@ hdl/pls_datapath.sv @@
`include "positional_list_store_unit_defines.svh"

module pls_datapath import pls_pkg::*; #(
  parameter int CAPACITY = PLS_CAPACITY
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         op_i,
  input  logic [15:0]        position_i,
  input  logic signed [31:0] value_i,
  input  pls_cmd_t           cmd_i,
  output pls_stat_t          stat_o,
  output logic signed [31:0] read_value_o,
  output logic [6:0]         entry_total_o,
  output logic               is_empty_o,
  output logic [1:0]         status_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [31:0]        mem_q [CAPACITY];
  logic [31:0]        rdata_q;
  logic [31:0]        wdata;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [CW-1:0]      count_q;
  logic [AW-1:0]      pos_q;
  logic [AW-1:0]      ptr_q;
  op_e                op_q;
  status_e            stat_q;
  logic signed [31:0] val_q;
  logic signed [31:0] read_value_q;
  logic [6:0]         entry_total_q;
  logic               is_empty_q;
  logic [1:0]         status_q;
  op_e                op_in;
  logic               pos_past;
  logic               is_full;
  status_e            stat_new;

  always_comb begin
    op_in    = op_e'(op_i);
    pos_past = 32'(position_i) >= 32'(count_q);
    is_full  = count_q == CW'(CAPACITY);
    case (op_in)
      OP_INSERT: stat_new = is_full ? ST_FULL : ST_OK;
      OP_DELETE: stat_new = pos_past ? ST_RANGE : ST_OK;
      OP_READ:   stat_new = pos_past ? ST_RANGE : ST_OK;
      default:   stat_new = ST_OK;
    endcase
    stat_o.go_shift  = (op_in == OP_INSERT && !is_full) ||
                       (op_in == OP_DELETE && !pos_past);
    stat_o.go_fetch  = op_in == OP_READ && !pos_past;
    stat_o.is_insert = op_q == OP_INSERT;
    if (op_q == OP_INSERT) begin
      stat_o.more = ptr_q > pos_q;
    end else begin
      stat_o.more = ((CW+1)'(ptr_q) + (CW+1)'(1)) < (CW+1)'(count_q);
    end
    if (cmd_i.fetch) begin
      rd_addr = pos_q;
    end else if (op_q == OP_INSERT) begin
      rd_addr = ptr_q - AW'(1);
    end else begin
      rd_addr = ptr_q + AW'(1);
    end
    wr_addr = cmd_i.put ? pos_q : ptr_q;
    wdata   = cmd_i.put ? val_q : rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write || cmd_i.put) begin
      mem_q[wr_addr] <= wdata;
    end
    if (cmd_i.read || cmd_i.fetch) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= op_in;
      val_q  <= value_i;
      stat_q <= stat_new;
      pos_q  <= pos_past ? AW'(count_q) : AW'(position_i);
      ptr_q  <= (op_in == OP_INSERT) ? AW'(count_q) : AW'(position_i);
    end else if (cmd_i.write) begin
      ptr_q <= (op_q == OP_INSERT) ? ptr_q - AW'(1) : ptr_q + AW'(1);
    end
    if (cmd_i.load_out) begin
      read_value_q  <= (op_q == OP_READ && stat_q == ST_OK) ? rdata_q : '0;
      entry_total_q <= 7'(count_q);
      is_empty_q    <= count_q == '0;
      status_q      <= stat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.latch && op_in == OP_CLEAR) begin
      count_q <= '0;
    end else if (cmd_i.put) begin
      count_q <= count_q + CW'(1);
    end else if (cmd_i.drop) begin
      count_q <= count_q - CW'(1);
    end
  end

  assign read_value_o  = read_value_q;
  assign entry_total_o = entry_total_q;
  assign is_empty_o    = is_empty_q;
  assign status_o      = status_q;

  `PLS_ASSERT_IMPLY(a_count_bound, 1'b1, count_q <= CW'(CAPACITY), "count past capacity")
  `PLS_ASSERT_IMPLY(a_put_at_pos, cmd_i.put, ptr_q == pos_q, "insert gap not at position")
  `PLS_ASSERT_IMPLY(a_put_room, cmd_i.put, !is_full, "insert into full list")

endmodule

@@ hdl/pls_controller.sv @@
`include "positional_list_store_unit_defines.svh"

module pls_controller import pls_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  pls_stat_t stat_i,
  output pls_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          if (stat_i.go_shift) begin
            state_d = S_SHIFT_RD;
          end else if (stat_i.go_fetch) begin
            state_d = S_FETCH;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_SHIFT_RD: begin
        if (stat_i.more) begin
          cmd_o.read = 1'b1;
          state_d    = S_SHIFT_WR;
        end else if (stat_i.is_insert) begin
          state_d = S_PUT;
        end else begin
          cmd_o.drop = 1'b1;
          state_d    = S_FINISH;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.write = 1'b1;
        state_d     = S_SHIFT_RD;
      end
      S_PUT: begin
        cmd_o.put = 1'b1;
        state_d   = S_FINISH;
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = cmd_o.load_out | (out_valid_q & out_stall_i);
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

  `PLS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, state_q != S_IDLE, "idle after accept")
  `PLS_ASSERT_IMPLY(a_load_free, cmd_o.load_out, !out_valid_q || !out_stall_i, "result overwritten")
  `PLS_ASSERT_NEXT(a_finish_holds, state_q == S_FINISH && out_valid_q && out_stall_i, state_q == S_FINISH, "finish left while stalled")

endmodule
